>>> hw/rtl/prmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmt_pkg
// Shared types and constants for the pending response match table.
// ----------------------------------------------------------------------------
package prmt_pkg;

    localparam int PRMT_TABLE_DEPTH = 16;
    localparam logic [7:0] PRMT_RX_API_RESET = 8'd144;

    // Result status codes
    localparam logic [1:0] ST_REGISTERED = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_MATCHED    = 2'd2;
    localparam logic [1:0] ST_NO_MATCH   = 2'd3;

    // Command codes
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_MATCH    = 1'b1;

    typedef struct packed {
        logic [7:0]  frame_id;
        logic [7:0]  response_id;
        logic [63:0] address;
        logic [7:0]  api_id;
        logic [7:0]  action;
    } prmt_entry_t;

    // Broadcast control for every cell in the row
    typedef struct packed {
        logic load_en;
        logic match_en;
        logic addr_mode;
    } prmt_op_t;

endpackage

>>> hw/rtl/prmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmt_cell
// One table slot: holds an entry, compares it with the lookup key, passes
// the oldest-hit selection down the row and shifts left on removal.
// ----------------------------------------------------------------------------
module prmt_cell
    import prmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  prmt_op_t    op,
    input  prmt_entry_t key,
    input  logic        prev_valid,
    input  logic        right_valid,
    input  prmt_entry_t right_entry,
    input  logic        seen_in,
    input  prmt_entry_t pick_in,
    output logic        valid,
    output prmt_entry_t entry,
    output logic        seen_out,
    output prmt_entry_t pick_out
);

    logic        valid_reg;
    logic        valid_next;
    prmt_entry_t entry_reg;
    prmt_entry_t entry_next;
    logic        id_hit;
    logic        addr_hit;
    logic        hit;

    assign id_hit   = (entry_reg.response_id == key.frame_id);
    assign addr_hit = (entry_reg.address == key.address);
    assign hit      = valid_reg && (entry_reg.api_id == key.api_id)
                      && (op.addr_mode ? addr_hit : id_hit);

    assign seen_out = seen_in || hit;
    assign pick_out = (hit && !seen_in) ? entry_reg : pick_in;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (op.load_en && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            entry_next = key;
        end
        else if (op.match_en && seen_out)
        begin
            // at or after the removed slot: close up from the right
            valid_next = right_valid;
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

>>> hw/rtl/pending_response_match_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_response_match_table
// Insertion-ordered table of frames awaiting a response, built as a row of
// compacting cells. Register appends, match removes the oldest hit.
// ----------------------------------------------------------------------------
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+------------------------------------------
// in      | in  | in_valid/in_stall  | command, frame_id, response_id, address,
//         |     |                    | api_id, action_tag
// out     | out | out_valid/out_stall| status, matched_action, entry_frame_id,
//         |     |                    | entry_response_id, entry_address,
//         |     |                    | entry_api_id
// cfg     | in  | cfg_valid/cfg_ready| cfg_data (receive_api_code)
//
// One item per cycle: every cell compares in parallel and the oldest-hit
// selection ripples along the row, so the result register loads in the
// cycle the item is accepted. Throughput is bound by the output register:
// in_stall is raised only while a result sits there and out_stall is high.
// Reset clears all slot valid bits and sets receive_api_code to 144; slot
// payloads are not reset. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pending_response_match_table
    import prmt_pkg::*;
#(
    parameter int TABLE_DEPTH = PRMT_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  frame_id,
    input  logic [7:0]  response_id,
    input  logic [63:0] address,
    input  logic [7:0]  api_id,
    input  logic [7:0]  action_tag,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  matched_action,
    output logic [7:0]  entry_frame_id,
    output logic [7:0]  entry_response_id,
    output logic [63:0] entry_address,
    output logic [7:0]  entry_api_id,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  rx_api_reg;
    logic        in_accept;
    prmt_op_t    op;
    prmt_entry_t key;

    logic        cell_valid [TABLE_DEPTH];
    prmt_entry_t cell_entry [TABLE_DEPTH];
    logic        seen_chain [TABLE_DEPTH+1];
    prmt_entry_t pick_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic        table_full;
    logic        found;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    prmt_entry_t result_reg;
    prmt_entry_t result_next;

    // config register; the user must write it only while idle, the block itself does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_api_reg <= PRMT_RX_API_RESET;
        else if (cfg_valid && cfg_ready)
            rx_api_reg <= cfg_data;
    end

    // input side
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign key.frame_id    = frame_id;
    assign key.response_id = response_id;
    assign key.address     = address;
    assign key.api_id      = api_id;
    assign key.action      = action_tag;

    assign op.load_en   = in_accept && (command == CMD_REGISTER);
    assign op.match_en  = in_accept && (command == CMD_MATCH);
    assign op.addr_mode = (api_id == rx_api_reg);

    // the cell row; hit selection flows left to right, shifts right to left
    assign seen_chain[0] = 1'b0;
    assign pick_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic        prev_v;
            logic        right_v;
            prmt_entry_t right_e;

            if (gi == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid
                assign prev_v = cell_valid[gi-1];
            end

            if (gi == TABLE_DEPTH-1)
            begin : g_last
                assign right_v = 1'b0;
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_v = cell_valid[gi+1];
                assign right_e = cell_entry[gi+1];
            end

            prmt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .key         (key),
                .prev_valid  (prev_v),
                .right_valid (right_v),
                .right_entry (right_e),
                .seen_in     (seen_chain[gi]),
                .pick_in     (pick_chain[gi]),
                .valid       (cell_valid[gi]),
                .entry       (cell_entry[gi]),
                .seen_out    (seen_chain[gi+1]),
                .pick_out    (pick_chain[gi+1])
            );

            assign valid_vec[gi] = cell_valid[gi];
        end
    endgenerate

    // packed table: full when the last slot is in use
    assign table_full = cell_valid[TABLE_DEPTH-1];
    assign found      = seen_chain[TABLE_DEPTH];

    // result register
    always_comb
    begin
        status_next    = status_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            result_next    = '0;
            if (command == CMD_REGISTER)
                status_next = table_full ? ST_FULL : ST_REGISTERED;
            else if (found)
            begin
                status_next = ST_MATCHED;
                result_next = pick_chain[TABLE_DEPTH];
            end
            else
                status_next = ST_NO_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign matched_action    = result_reg.action;
    assign entry_frame_id    = result_reg.frame_id;
    assign entry_response_id = result_reg.response_id;
    assign entry_address     = result_reg.address;
    assign entry_api_id      = result_reg.api_id;

    // valid slots always form a prefix of the row
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("table not packed");

    // a register into a non-full table adds exactly one entry
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_REGISTER && !table_full) |=>
        ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("append did not add one entry");

    // a successful match removes exactly one entry
    a_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_MATCH && found) |=>
        ($countones(valid_vec) == $past($countones(valid_vec)) - 1))
        else $error("match did not remove one entry");

    // a register into a full table reports the drop and leaves it full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_REGISTER && table_full) |=>
        (status == ST_FULL && table_full))
        else $error("full table drop not reported");

endmodule
